/* rtl/core/truth_table_to_anf_core_assert.svh */
// assertion macros shared by the anf transform rtl
`ifndef TRUTH_TABLE_TO_ANF_CORE_ASSERT_SVH
`define TRUTH_TABLE_TO_ANF_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TTANF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TTANF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ttanf_pkg.sv */
// shared types and constants of the anf transform core
package ttanf_pkg;

    localparam int CFG_W = 4;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic pos_zero;
        logic sub_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/core/truth_table_to_anf_core.sv */
// one item at a time: the input stalls from accept until the coefficient is finished
// index 0 goes straight to finish; any other index walks its proper subsets in the
// coefficient store, one read per cycle, then drains; finish waits for a free output register
// reset (synchronous, active low) clears the position, the variable count and the control state
// the coefficient store is not cleared; every entry is written before it is read
module truth_table_to_anf_core
    import ttanf_pkg::*;
#(
    parameter int MAX_VARS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_value_bit,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_coefficient,
    output logic             o_last
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ttanf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ttanf_dp #(
        .MAX_VARS (MAX_VARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_value_bit   (i_value_bit),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_coefficient (o_coefficient),
        .o_last        (o_last)
    );

endmodule

/* rtl/core/ttanf_ctrl.sv */
// controller state machine of the anf transform core
`include "truth_table_to_anf_core_assert.svh"

module ttanf_ctrl
    import ttanf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_in_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // index 0 has no proper subsets
                    n_state = i_status.pos_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.sub_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    `TTANF_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, o_cmd.load, r_state != ST_IDLE, "load did not leave idle")
    `TTANF_ASSERT_SAME(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.load, o_cmd.step, o_cmd.finish}), "more than one command")
    `TTANF_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, o_cmd.finish, !o_in_stall, "finish did not return to idle")

endmodule

/* rtl/core/ttanf_dp.sv */
// datapath of the anf transform core: position, subset walk, coefficient store, output register
`include "truth_table_to_anf_core_assert.svh"

module ttanf_dp
    import ttanf_pkg::*;
#(
    parameter int MAX_VARS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl_cmd        i_cmd,
    output t_dp_status       o_status,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_value_bit,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_coefficient,
    output logic             o_last
);

    localparam int AW    = MAX_VARS;
    localparam int DEPTH = 1 << MAX_VARS;

    logic [CFG_W-1:0] r_num_vars;
    logic [AW-1:0]    r_position;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    r_sub;
    logic             r_acc;
    logic             r_rd_vld;
    logic             r_rd_data;
    logic             r_store [DEPTH];
    logic             r_out_valid;
    logic             r_out_coef;
    logic             r_out_last;

    logic [4:0]       w_nv;
    logic [AW-1:0]    w_mask;
    logic [AW-1:0]    w_pos_cur;
    logic [AW-1:0]    w_sub_next;
    logic             w_is_last;

    // variable counts above MAX_VARS act as MAX_VARS
    assign w_nv = ({1'b0, r_num_vars} > 5'(MAX_VARS)) ? 5'(MAX_VARS) : {1'b0, r_num_vars};

    for (genvar g = 0; g < AW; g++) begin : g_mask
        assign w_mask[g] = (w_nv > 5'(g));
    end

    assign w_pos_cur  = r_position & w_mask;
    // next smaller subset of the current index
    assign w_sub_next = (r_sub - AW'(1)) & r_pos;
    assign w_is_last  = (r_pos == w_mask);

    assign o_status.pos_zero = (w_pos_cur == '0);
    assign o_status.sub_last = (w_sub_next == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= '0;
        end else if (i_cfg_we) begin
            r_num_vars <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else if (i_cmd.finish) begin
            r_position <= w_is_last ? '0 : ((r_pos + AW'(1)) & w_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= w_pos_cur;
            r_sub <= w_pos_cur;
        end else if (i_cmd.step) begin
            r_sub <= w_sub_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= i_value_bit;
        end else if (r_rd_vld) begin
            r_acc <= r_acc ^ r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_store[r_pos] <= r_acc;
        end
        if (i_cmd.step) begin
            r_rd_data <= r_store[w_sub_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_coef <= r_acc;
            r_out_last <= w_is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_last        = r_out_last;

    `TTANF_ASSERT_SAME(a_no_read_at_finish, i_clk, i_rst_n, i_cmd.finish, !r_rd_vld, "finish with read in flight")
    `TTANF_ASSERT_SAME(a_step_nonzero_pos, i_clk, i_rst_n, i_cmd.step, r_pos != '0, "subset walk on index zero")
    `TTANF_ASSERT_NEXT(a_finish_fills_out, i_clk, i_rst_n, i_cmd.finish, r_out_valid, "finish lost its item")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the streaming truth table to anf transform core
`timescale 1ns / 100ps

module testbench
    import ttanf_pkg::*;
();

    localparam int ANF_MAX = 10;
    localparam int STORE_SIZE = 1 << ANF_MAX;
    localparam int TARGET_ITEMS = 570;

    typedef struct packed {
        logic coefficient;
        logic last;
    } t_anf_term;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_value_bit;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_coefficient;
    logic             o_last;

    // predictor state
    logic      anf_mem [STORE_SIZE];
    int        var_count;
    int        next_index;
    t_anf_term expected_terms [$];

    int items_sent;
    int terms_checked;
    int tables_closed;
    int fail_count;
    bit gaps_on;
    bit stall_on;

    truth_table_to_anf_core #(
        .MAX_VARS(ANF_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_bit  (i_value_bit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_coefficient(o_coefficient),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // variable counts above the maximum behave as the maximum
    function automatic int table_mask();
        int nv;
        nv = (var_count > ANF_MAX) ? ANF_MAX : var_count;
        return (1 << nv) - 1;
    endfunction

    // xor the input bit with the coefficients of every proper subset of the index
    function automatic t_anf_term mobius_step(logic value);
        t_anf_term term;
        int        mask;
        int        idx;
        int        sub;
        logic      acc;
        mask = table_mask();
        idx  = next_index & mask;
        acc  = value;
        if (idx != 0) begin
            sub = idx;
            do begin
                sub = (sub - 1) & idx;
                acc ^= anf_mem[sub];
            end while (sub != 0);
        end
        anf_mem[idx]     = acc;
        term.coefficient = acc;
        term.last        = (idx == mask);
        next_index       = term.last ? 0 : ((idx + 1) & mask);
        return term;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= stall_on && ($urandom_range(99) < 16);
    end

    always @(posedge i_clk) begin : check_terms
        t_anf_term want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_terms.size() == 0) begin
                $error("unexpected item: coefficient %b last %b", o_coefficient, o_last);
                fail_count++;
            end else begin
                want = expected_terms.pop_front();
                terms_checked++;
                if (want.last)
                    tables_closed++;
                if (o_coefficient !== want.coefficient) begin
                    $error("coefficient: expected %b, actual %b", want.coefficient,
                           o_coefficient);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // valid stays high into the next call unless a gap is taken
    task automatic send_bit(input logic value);
        i_in_valid  <= 1'b1;
        i_value_bit <= value;
        do @(posedge i_clk); while (o_in_stall);
        expected_terms.insert(expected_terms.size(), mobius_step(value));
        items_sent++;
        if (gaps_on && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic hold_and_drain();
        i_in_valid <= 1'b0;
        while (expected_terms.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_var_count(input int count);
        hold_and_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        var_count = count;
    endtask

    // reset leaves zero variables: every item closes a one-bit table
    task automatic test_zero_vars();
        send_bit(1'b0);
        send_bit(1'b1);
    endtask

    task automatic test_small_tables();
        write_var_count(2);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        // close the table, then grow it, stop part way and shrink it so the position is masked down
        write_var_count(3);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        write_var_count(1);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
    endtask

    task automatic test_oversized_count();
        write_var_count(15);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
    endtask

    task automatic test_widest_table();
        write_var_count(ANF_MAX);
        for (int i = 0; i < 64; i++) begin
            send_bit(1'($urandom_range(1)));
            if (i == 31)
                hold_and_drain();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_var_count(5);
        repeat (96) send_bit(1'($urandom_range(1)));
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_random_tables();
        int pick;
        int nv;
        int room;
        int count;
        bit sparse;
        while (items_sent < TARGET_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70)
                nv = $urandom_range(5);
            else if (pick < 85)
                nv = $urandom_range(7, 6);
            else if (pick < 93)
                nv = $urandom_range(ANF_MAX, 8);
            else
                nv = $urandom_range(15, ANF_MAX + 1);
            write_var_count(nv);
            room = table_mask() + 1 - (next_index & table_mask());
            // mostly finish the table, sometimes break off part way; runs above 64 items are cut short
            count = ($urandom_range(9) < 8) ? room : $urandom_range(room, 1);
            if (count > 64)
                count = $urandom_range(64, 16);
            sparse = ($urandom_range(3) == 0);
            for (int i = 0; i < count; i++) begin
                send_bit(sparse ? 1'($urandom_range(7) == 0) : 1'($urandom_range(1)));
                if (i == count / 2 && $urandom_range(7) == 0)
                    hold_and_drain();
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_value_bit   <= 1'b0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        var_count      = 0;
        next_index     = 0;
        items_sent     = 0;
        terms_checked  = 0;
        tables_closed  = 0;
        fail_count     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_vars();
        test_small_tables();
        test_oversized_count();
        test_widest_table();
        test_back_to_back();
        test_random_tables();

        hold_and_drain();
        repeat (STORE_SIZE + 8) @(posedge i_clk);
        $display("run covered %0d truth-table items and %0d coefficients, %0d tables closed,",
                 items_sent, terms_checked, tables_closed);
        $display("with variable counts from zero to oversized and mid-table resizes");
        if (fail_count == 0 && expected_terms.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ttanf_pkg.sv
rtl/core/ttanf_ctrl.sv
rtl/core/ttanf_dp.sv
rtl/core/truth_table_to_anf_core.sv
tb/testbench.sv
